// ===== design/unordered_set_table_unit_defines.svh =====
// assertion macros used by the set table rtl
// no dependencies; included by ust_back, the module that carries assertions
`ifndef UNORDERED_SET_TABLE_UNIT_DEFINES_SVH
`define UNORDERED_SET_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define UST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define UST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ust_pkg.sv =====
// shared types and constants of the set table unit
// no dependencies; imported by the front, back and top modules of the block
package ust_pkg;

    localparam int ELEM_W      = 32;
    localparam int COUNT_OUT_W = 7;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_QUERY  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                     kind;
        logic signed [ELEM_W-1:0]  element;
    } item_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic   valid;
        item_t  item;
    } cmd_t;

endpackage

// ===== design/ust_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module ust_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== design/ust_front.sv =====
// front end: takes command beats into a two-entry queue
// depends on ust_pkg
module ust_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [1:0]                 kind,
    input  logic signed [31:0]         element,
    output logic                       busy,
    output ust_pkg::cmd_t              cmd,
    input  logic                       pop
);
    import ust_pkg::*;

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        push;
    item_t       in_item;

    assign busy = (fill_reg == 2'd2);
    assign push = start && !busy;

    // classify the raw operation code
    always_comb
    begin
        in_item.element = element;
        unique case (kind)
            KIND_CLEAR:  in_item.kind = KIND_CLEAR;
            KIND_INSERT: in_item.kind = KIND_INSERT;
            KIND_REMOVE: in_item.kind = KIND_REMOVE;
            default:     in_item.kind = KIND_QUERY;
        endcase
    end

    assign cmd.valid = (fill_reg != 2'd0);
    assign cmd.item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (pop && cmd.valid);
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop && cmd.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== design/ust_back.sv =====
// back end: linear search over the element ram, then insert, remove, clear or query
// depends on ust_pkg, ust_ram and the assertion macro header
`include "unordered_set_table_unit_defines.svh"

module ust_back #(
    parameter int CAPACITY = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ust_pkg::cmd_t       cmd,
    output logic                pop,
    output logic                done,
    output logic                was_present,
    output logic [6:0]          member_count,
    output logic                is_empty,
    output logic signed [31:0]  first_element,
    output logic                select_error,
    output logic                insert_dropped
);
    import ust_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_ACT,
        S_MOVE,
        S_REPORT
    } state_t;

    state_t                state_reg, state_next;
    kind_t                 kind_reg, kind_next;
    logic [ELEM_W-1:0]     elem_reg, elem_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]      slot_reg, slot_next;
    logic                  found_reg, found_next;
    logic                  dropped_reg, dropped_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ELEM_W-1:0]     first_reg, first_next;

    logic                  done_reg;
    logic                  present_out_reg;
    logic [COUNT_OUT_W-1:0] count_out_reg;
    logic                  empty_out_reg;
    logic [ELEM_W-1:0]     first_out_reg;
    logic                  dropped_out_reg;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ELEM_W-1:0]     ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ELEM_W-1:0]     ram_rdata;

    logic [CNT_W-1:0]      count_m1;
    logic [31:0]           count_wide;

    ust_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign count_m1   = count_reg - CNT_W'(1);
    assign count_wide = 32'(count_reg);

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        elem_next    = elem_reg;
        cmp_idx_next = cmp_idx_reg;
        slot_next    = slot_reg;
        found_next   = found_reg;
        dropped_next = dropped_reg;
        count_next   = count_reg;
        first_next   = first_reg;
        pop          = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = slot_reg;
        ram_wdata    = elem_reg;
        ram_raddr    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    pop          = 1'b1;
                    kind_next    = cmd.item.kind;
                    elem_next    = cmd.item.element;
                    cmp_idx_next = '0;
                    found_next   = 1'b0;
                    dropped_next = 1'b0;
                    state_next   = (count_reg == '0) ? S_ACT : S_SEARCH;
                end
            end

            // rdata holds the entry at cmp_idx; fetch the one after it
            S_SEARCH:
            begin
                ram_raddr = IDX_W'(cmp_idx_reg + IDX_W'(1));
                if (ram_rdata == elem_reg)
                begin
                    found_next = 1'b1;
                    slot_next  = cmp_idx_reg;
                    state_next = S_ACT;
                end
                else if (CNT_W'(cmp_idx_reg) == count_m1)
                begin
                    state_next = S_ACT;
                end
                else
                begin
                    cmp_idx_next = IDX_W'(cmp_idx_reg + IDX_W'(1));
                end
            end

            S_ACT:
            begin
                state_next = S_REPORT;
                unique case (kind_reg)
                    KIND_CLEAR:
                    begin
                        count_next = '0;
                    end
                    KIND_INSERT:
                    begin
                        if (!found_reg)
                        begin
                            if (count_reg < CNT_W'(CAPACITY))
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[IDX_W-1:0];
                                ram_wdata  = elem_reg;
                                count_next = count_reg + CNT_W'(1);
                                if (count_reg == '0)
                                begin
                                    first_next = elem_reg;
                                end
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                    end
                    KIND_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            if (CNT_W'(slot_reg) == count_m1)
                            begin
                                count_next = count_m1;
                            end
                            else
                            begin
                                // fetch the last entry to fill the hole
                                ram_raddr  = count_m1[IDX_W-1:0];
                                state_next = S_MOVE;
                            end
                        end
                    end
                    KIND_QUERY:
                    begin
                        state_next = S_REPORT;
                    end
                endcase
            end

            S_MOVE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = slot_reg;
                ram_wdata  = ram_rdata;
                count_next = count_m1;
                if (slot_reg == '0)
                begin
                    first_next = ram_rdata;
                end
                state_next = S_REPORT;
            end

            S_REPORT:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            kind_reg        <= KIND_QUERY;
            elem_reg        <= '0;
            cmp_idx_reg     <= '0;
            slot_reg        <= '0;
            found_reg       <= 1'b0;
            dropped_reg     <= 1'b0;
            count_reg       <= '0;
            first_reg       <= '0;
            done_reg        <= 1'b0;
            present_out_reg <= 1'b0;
            count_out_reg   <= '0;
            empty_out_reg   <= 1'b1;
            first_out_reg   <= '0;
            dropped_out_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            elem_reg    <= elem_next;
            cmp_idx_reg <= cmp_idx_next;
            slot_reg    <= slot_next;
            found_reg   <= found_next;
            dropped_reg <= dropped_next;
            count_reg   <= count_next;
            first_reg   <= first_next;
            done_reg    <= (state_reg == S_REPORT);
            if (state_reg == S_REPORT)
            begin
                present_out_reg <= found_reg;
                count_out_reg   <= count_wide[COUNT_OUT_W-1:0];
                empty_out_reg   <= (count_reg == '0);
                first_out_reg   <= (count_reg == '0) ? '0 : first_reg;
                dropped_out_reg <= dropped_reg;
            end
        end
    end

    assign done           = done_reg;
    assign was_present    = present_out_reg;
    assign member_count   = count_out_reg;
    assign is_empty       = empty_out_reg;
    assign first_element  = first_out_reg;
    assign select_error   = empty_out_reg;
    assign insert_dropped = dropped_out_reg;

    `UST_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `UST_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg, "done held for two cycles")
    `UST_ASSERT_NOW(a_search_range, clk, rst_n, state_reg == S_SEARCH, CNT_W'(cmp_idx_reg) < count_reg, "search past used slots")
    `UST_ASSERT_NOW(a_drop_full, clk, rst_n, done_reg && dropped_out_reg, count_reg == CNT_W'(CAPACITY), "insert dropped while not full")
    `UST_ASSERT_NEXT(a_move_shrinks, clk, rst_n, state_reg == S_MOVE, count_reg == $past(count_m1), "move did not shrink the set")

endmodule

// ===== design/unordered_set_table_unit.sv =====
// set of distinct 32-bit integers in an unordered table with a linear search.
// a command beat (kind, element) is taken at a clock edge with start high and
// busy low; a two-beat queue holds commands while the back end works. every
// command gives exactly one result beat, marked by done for one cycle, and the
// receiver cannot stall it. once the back end picks a command up, it searches
// the used entries (skipped when the set is empty) until a hit or the last
// entry, then acts on the table, then for a remove that hit before the last
// slot moves the last entry into the hole, then reports. the search reads the
// element ram one entry per cycle through its single read port. the result
// registers are loaded in the report state and done rises the cycle after it.
// the element ram needs no clearing after reset: only data from slots below
// the count is ever used.
// depends on ust_pkg, ust_front, ust_back

module unordered_set_table_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    // command side
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          kind,
    input  logic signed [31:0]  element,
    // result side
    output logic                done,
    output logic                was_present,
    output logic [6:0]          member_count,
    output logic                is_empty,
    output logic signed [31:0]  first_element,
    output logic                select_error,
    output logic                insert_dropped
);
    import ust_pkg::*;

    // queue head handed from front to back
    cmd_t  cmd;
    logic  pop;

    // front: accepts beats and decodes the operation
    ust_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .kind    (kind),
        .element (element),
        .busy    (busy),
        .cmd     (cmd),
        .pop     (pop)
    );

    // back: search, update the table and report
    ust_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .pop            (pop),
        .done           (done),
        .was_present    (was_present),
        .member_count   (member_count),
        .is_empty       (is_empty),
        .first_element  (first_element),
        .select_error   (select_error),
        .insert_dropped (insert_dropped)
    );

endmodule
